[sv/rqs_pkg.sv]
// rqs_pkg: shared types, codes and sizes of the ready queue selector
// used by rqs_ctrl, rqs_datapath and ready_queue_select_top; no dependencies
package rqs_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int PID_W   = 8;
  localparam int TIME_W  = 32;
  localparam int PRIO_W  = 8;
  localparam int WGT_W   = 8;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int PROD_W  = TIME_W + WGT_W;
  localparam int KEY_W   = PROD_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_WEIGHT = 1'd1;

  // selection policies; the unused code behaves as priority aging
  localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AGING = 2'd2;

  // operations
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_REMOVE,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic enqueue;   // enqueue transaction accepted
    logic start;     // dequeue transaction accepted
    logic scan;      // read one slot into the compare pipeline
    logic remove;    // take the winner out of the queue
    logic load_out;  // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last; // the slot being read is the last one
  } stat_t;

endpackage

[sv/rqs_ctrl.sv]
// rqs_ctrl: state machine sequencing enqueue, slot scan and removal
// depends on rqs_pkg; drives rqs_datapath through rqs_pkg::cmd_t
module rqs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           operation,
  output logic           out_valid,
  input  logic           out_ready,
  output rqs_pkg::cmd_t  cmd,
  input  rqs_pkg::stat_t stat
);

  rqs_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rqs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (operation == rqs_pkg::OP_DEQUEUE) ? rqs_pkg::S_SCAN
                                                          : rqs_pkg::S_FINISH;
        end
      end
      rqs_pkg::S_SCAN: begin
        if (stat.scan_last) begin
          state_next = rqs_pkg::S_DRAIN1;
        end
      end
      rqs_pkg::S_DRAIN1: state_next = rqs_pkg::S_DRAIN2;
      rqs_pkg::S_DRAIN2: state_next = rqs_pkg::S_REMOVE;
      rqs_pkg::S_REMOVE: state_next = rqs_pkg::S_FINISH;
      rqs_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = rqs_pkg::S_IDLE;
        end
      end
      default: state_next = rqs_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      rqs_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.enqueue = in_valid && (operation == rqs_pkg::OP_ENQUEUE);
        cmd.start   = in_valid && (operation == rqs_pkg::OP_DEQUEUE);
      end
      rqs_pkg::S_SCAN:   cmd.scan     = 1'b1;
      rqs_pkg::S_REMOVE: cmd.remove   = 1'b1;
      rqs_pkg::S_FINISH: cmd.load_out = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // output transaction pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[sv/rqs_datapath.sv]
// rqs_datapath: slot store, three-stage scan and compare pipeline, output register
// depends on rqs_pkg; sequenced by rqs_ctrl
module rqs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  rqs_pkg::cmd_t                      cmd,
  output rqs_pkg::stat_t                     stat,
  input  logic                               cfg_write,
  input  logic [rqs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rqs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [rqs_pkg::PID_W-1:0]          process_id,
  input  logic [rqs_pkg::TIME_W-1:0]         arrived_at,
  input  logic [rqs_pkg::PRIO_W-1:0]         base_priority,
  input  logic [rqs_pkg::TIME_W-1:0]         now_time,
  output logic [rqs_pkg::STAT_W-1:0]         status,
  output logic [rqs_pkg::PID_W-1:0]          selected_id
);

  localparam int D  = rqs_pkg::QUEUE_DEPTH;
  localparam int IW = rqs_pkg::IDX_W;
  localparam int CW = rqs_pkg::CNT_W;

  // configuration registers
  logic [rqs_pkg::MODE_W-1:0] mode;
  logic [rqs_pkg::WGT_W-1:0]  wait_weight;

  // slot store
  logic                        slot_valid    [D];
  logic [rqs_pkg::PID_W-1:0]   slot_pid      [D];
  logic [rqs_pkg::TIME_W-1:0]  slot_arrival  [D];
  logic [rqs_pkg::PRIO_W-1:0]  slot_priority [D];
  logic [rqs_pkg::TIME_W-1:0]  slot_stamp    [D];
  logic [CW-1:0]               slot_order    [D];
  logic [CW-1:0]               insert_counter;

  // free slot search
  logic [IW-1:0] free_idx;
  logic          full;

  // scan control
  logic [IW-1:0]              scan_idx;
  logic [rqs_pkg::TIME_W-1:0] now_hold;

  // stage one: slot read and waiting time
  logic                        s1_valid;
  logic [IW-1:0]               s1_idx;
  logic [rqs_pkg::PID_W-1:0]   s1_pid;
  logic [rqs_pkg::TIME_W-1:0]  s1_arrival;
  logic [rqs_pkg::PRIO_W-1:0]  s1_priority;
  logic [rqs_pkg::TIME_W-1:0]  s1_wait;
  logic [CW-1:0]               s1_order;

  // stage two: aged key
  logic                        s2_valid;
  logic [IW-1:0]               s2_idx;
  logic [rqs_pkg::PID_W-1:0]   s2_pid;
  logic [rqs_pkg::TIME_W-1:0]  s2_arrival;
  logic [rqs_pkg::KEY_W-1:0]   s2_key;
  logic [CW-1:0]               s2_order;
  logic [rqs_pkg::PROD_W-1:0]  prod;
  logic [rqs_pkg::KEY_W-1:0]   key_calc;

  // current winner
  logic                        best_found;
  logic [IW-1:0]               best_idx;
  logic [rqs_pkg::PID_W-1:0]   best_pid;
  logic [rqs_pkg::TIME_W-1:0]  best_arrival;
  logic [rqs_pkg::KEY_W-1:0]   best_key;
  logic [CW-1:0]               best_order;
  logic                        cand_beats;

  // result waiting for the output register
  logic [rqs_pkg::STAT_W-1:0]  res_status;
  logic [rqs_pkg::PID_W-1:0]   res_id;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= rqs_pkg::MODE_FCFS;
      wait_weight <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rqs_pkg::REG_MODE:        mode        <= cfg_data[rqs_pkg::MODE_W-1:0];
        rqs_pkg::REG_WAIT_WEIGHT: wait_weight <= cfg_data[rqs_pkg::WGT_W-1:0];
        default:                  mode        <= mode;
      endcase
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    full = 1'b1;
    for (int i = 0; i < D; i++) begin
      if (!slot_valid[i]) begin
        full = 1'b0;
      end
    end
  end

  // valid bits and insertion counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) begin
        slot_valid[i] <= 1'b0;
      end
      insert_counter <= '0;
    end else if (cmd.enqueue && !full) begin
      slot_valid[free_idx]     <= 1'b1;
      insert_counter           <= insert_counter + CW'(1);
    end else if (cmd.remove && best_found) begin
      slot_valid[best_idx] <= 1'b0;
      if (insert_counter != '0) begin
        insert_counter <= insert_counter - CW'(1);
      end
    end
  end

  // entry payload and rank; removal closes the gap in the ranks
  always_ff @(posedge clk) begin
    if (cmd.enqueue && !full) begin
      slot_pid[free_idx]      <= process_id;
      slot_arrival[free_idx]  <= arrived_at;
      slot_priority[free_idx] <= base_priority;
      slot_stamp[free_idx]    <= now_time;
      slot_order[free_idx]    <= insert_counter;
    end else if (cmd.remove && best_found) begin
      for (int i = 0; i < D; i++) begin
        if (slot_valid[i] && (slot_order[i] > best_order)) begin
          slot_order[i] <= slot_order[i] - CW'(1);
        end
      end
    end
  end

  // scan index and held time
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.start) begin
      scan_idx <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      now_hold <= now_time;
    end
  end

  assign stat.scan_last = (scan_idx == IW'(D - 1));

  // stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.scan && slot_valid[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    s1_idx      <= scan_idx;
    s1_pid      <= slot_pid[scan_idx];
    s1_arrival  <= slot_arrival[scan_idx];
    s1_priority <= slot_priority[scan_idx];
    s1_wait     <= now_hold - slot_stamp[scan_idx];
    s1_order    <= slot_order[scan_idx];
  end

  // stage two: priority plus weighted waiting time, full width
  assign prod     = s1_wait * wait_weight;
  assign key_calc = {1'b0, prod} + {{(rqs_pkg::KEY_W - rqs_pkg::PRIO_W){1'b0}}, s1_priority};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx     <= s1_idx;
    s2_pid     <= s1_pid;
    s2_arrival <= s1_arrival;
    s2_key     <= key_calc;
    s2_order   <= s1_order;
  end

  // policy compare; ties go to the earlier inserted entry
  always_comb begin
    case (mode)
      rqs_pkg::MODE_FCFS: begin
        cand_beats = (s2_arrival != best_arrival) ? (s2_arrival < best_arrival)
                                                  : (s2_order < best_order);
      end
      rqs_pkg::MODE_RR: cand_beats = (s2_order < best_order);
      default: begin
        cand_beats = (s2_key != best_key) ? (s2_key > best_key)
                                          : (s2_order < best_order);
      end
    endcase
  end

  // winner tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (cmd.start) begin
      best_found <= 1'b0;
    end else if (s2_valid && (!best_found || cand_beats)) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && (!best_found || cand_beats)) begin
      best_idx     <= s2_idx;
      best_pid     <= s2_pid;
      best_arrival <= s2_arrival;
      best_key     <= s2_key;
      best_order   <= s2_order;
    end
  end

  // result of the current transaction
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      res_status <= full ? rqs_pkg::ST_FULL : rqs_pkg::ST_OK;
      res_id     <= '0;
    end else if (cmd.remove) begin
      res_status <= best_found ? rqs_pkg::ST_OK : rqs_pkg::ST_EMPTY;
      res_id     <= best_found ? best_pid : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= res_status;
      selected_id <= res_id;
    end
  end

endmodule

[sv/ready_queue_select_top.sv]
// Ready queue selector: a queue of up to rqs_pkg::QUEUE_DEPTH process entries. An enqueue
// transaction stores the entry in the lowest free slot and delivers its result through the
// finish state and the output register. A dequeue transaction reads every slot in turn
// through a three-stage read, multiply and compare pipeline and removes the winner; the
// single slot read port and compare unit mean that the slots are read one after another.
// One transaction is worked on at a time; the result waits in an output register until taken.
// The user is to write mode and wait_weight only while idle; the block does not enforce it.
// depends on rqs_pkg, rqs_ctrl and rqs_datapath
module ready_queue_select_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rqs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rqs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [rqs_pkg::PID_W-1:0]          process_id,
  input  logic [rqs_pkg::TIME_W-1:0]         arrived_at,
  input  logic [rqs_pkg::PRIO_W-1:0]         base_priority,
  input  logic [rqs_pkg::TIME_W-1:0]         now_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rqs_pkg::STAT_W-1:0]         status,
  output logic [rqs_pkg::PID_W-1:0]          selected_id
);

  rqs_pkg::cmd_t  cmd;
  rqs_pkg::stat_t stat;

  // sequencing
  rqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // queue store and selection
  rqs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .process_id    (process_id),
    .arrived_at    (arrived_at),
    .base_priority (base_priority),
    .now_time      (now_time),
    .status        (status),
    .selected_id   (selected_id)
  );

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for ready_queue_select_top; a directed table and then
// random enqueue/dequeue traffic, checked against an in-bench prediction of the queue
// depends on rqs_pkg and the ready queue selector RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rqs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 300;
  localparam int CFG_SETTLE    = 4;
  localparam int TAIL_CYCLES   = QUEUE_DEPTH + 8;
  localparam int RANDOM_CHUNKS = 8;
  localparam int CHUNK_ITEMS   = 50;
  localparam int REPORT_LIMIT  = 10;
  localparam int NROWS         = 18;
  // spare policy code, handled as priority aging
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic              op;
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [PID_W-1:0]  id;
  } dispatch_t;

  // fixed rows carry their own expectation, pred rows are checked against the prediction
  typedef enum {ROW_FIXED, ROW_PRED, ROW_MODE, ROW_WEIGHT} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] now;
    int                reps;
    logic [STAT_W-1:0] st;
    logic [PID_W-1:0]  id;
    logic [CFG_DATA_W-1:0] rval;
  } row_t;

  // dut ports
  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  operation;
  logic [PID_W-1:0]      process_id;
  logic [TIME_W-1:0]     arrived_at;
  logic [PRIO_W-1:0]     base_priority;
  logic [TIME_W-1:0]     now_time;
  logic                  out_valid;
  logic                  out_ready;
  logic [STAT_W-1:0]     status;
  logic [PID_W-1:0]      selected_id;

  // predicted queue contents and registers
  logic              occ     [QUEUE_DEPTH];
  logic [PID_W-1:0]  q_pid   [QUEUE_DEPTH];
  logic [TIME_W-1:0] q_arr   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] q_prio  [QUEUE_DEPTH];
  logic [TIME_W-1:0] q_stamp [QUEUE_DEPTH];
  logic [15:0]       q_rank  [QUEUE_DEPTH];
  logic [15:0]       next_rank;
  logic [MODE_W-1:0] sel_mode;
  logic [WGT_W-1:0]  aging_wt;

  dispatch_t owed_dispatch [$];

  int bad;
  int n_results;
  int n_enq;
  int n_deq;
  int n_full;
  int n_empty;
  int n_reg_writes;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests;
  int hold_served;
  int cycle_count = 0;

  // directed table
  row_t plan [NROWS] = '{
    //  kind        op          pid    arrival       prio   now           n   status    id     value
    '{ROW_FIXED,  OP_DEQUEUE, 8'hFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 1, ST_EMPTY, 8'h00, 8'h00},
    '{ROW_FIXED,  OP_ENQUEUE, 8'hFF, 32'hFFFFFFFF, 8'hFF, 32'h00000000, 1, ST_OK,    8'h00, 8'h00},
    '{ROW_FIXED,  OP_ENQUEUE, 8'h00, 32'h00000000, 8'h00, 32'hFFFFFFFF, 1, ST_OK,    8'h00, 8'h00},
    // same arrival as the entry before, the earlier one must win
    '{ROW_PRED,   OP_ENQUEUE, 8'h5A, 32'h00000000, 8'h80, 32'h0000000A, 1, ST_OK,    8'h00, 8'h00},
    '{ROW_PRED,   OP_DEQUEUE, 8'h00, 32'h00000000, 8'h00, 32'h00000014, 1, ST_OK,    8'h00, 8'h00},
    '{ROW_MODE,   OP_ENQUEUE, 8'h00, 32'h0,        8'h00, 32'h0,        0, ST_OK,    8'h00,
      8'(MODE_AGING)},
    '{ROW_WEIGHT, OP_ENQUEUE, 8'h00, 32'h0,        8'h00, 32'h0,        0, ST_OK,    8'h00, 8'hFF},
    // stamp just below the wrap, so the wait wraps round at the next dequeue
    '{ROW_PRED,   OP_ENQUEUE, 8'h33, 32'h00000007, 8'h01, 32'hFFFFFFF0, 1, ST_OK,    8'h00, 8'h00},
    '{ROW_PRED,   OP_DEQUEUE, 8'h00, 32'h00000000, 8'h00, 32'h00000005, 1, ST_OK,    8'h00, 8'h00},
    // spare mode code with the upper data bits set
    '{ROW_MODE,   OP_ENQUEUE, 8'h00, 32'h0,        8'h00, 32'h0,        0, ST_OK,    8'h00, 8'hFF},
    '{ROW_WEIGHT, OP_ENQUEUE, 8'h00, 32'h0,        8'h00, 32'h0,        0, ST_OK,    8'h00, 8'h00},
    '{ROW_PRED,   OP_ENQUEUE, 8'h44, 32'h00000003, 8'hFF, 32'h00000064, 1, ST_OK,    8'h00, 8'h00},
    '{ROW_PRED,   OP_DEQUEUE, 8'h00, 32'h00000000, 8'h00, 32'h00000190, 1, ST_OK,    8'h00, 8'h00},
    '{ROW_MODE,   OP_ENQUEUE, 8'h00, 32'h0,        8'h00, 32'h0,        0, ST_OK,    8'h00,
      8'(MODE_RR)},
    // fill the remaining slots, then one enqueue too many
    '{ROW_PRED,   OP_ENQUEUE, 8'h60, 32'h000003E8, 8'h0A, 32'h000000C8, 14, ST_OK,   8'h00, 8'h00},
    '{ROW_FIXED,  OP_ENQUEUE, 8'h77, 32'h00000000, 8'h00, 32'h0000012C, 1, ST_FULL,  8'h00, 8'h00},
    '{ROW_PRED,   OP_DEQUEUE, 8'h00, 32'h00000000, 8'h00, 32'h000001F4, 1, ST_OK,    8'h00, 8'h00},
    '{ROW_PRED,   OP_DEQUEUE, 8'h00, 32'h00000000, 8'h00, 32'h000001F5, 1, ST_OK,    8'h00, 8'h00}
  };

  logic [MODE_W-1:0] chunk_mode [RANDOM_CHUNKS] = '{
    MODE_AGING, MODE_FCFS, MODE_RR, MODE_SPARE, MODE_AGING, MODE_FCFS, MODE_RR, MODE_AGING
  };

  ready_queue_select_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .process_id    (process_id),
    .arrived_at    (arrived_at),
    .base_priority (base_priority),
    .now_time      (now_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .selected_id   (selected_id)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // true when slot a is to be taken ahead of slot b
  function automatic bit outranks(int a, int b, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] wait_a;
    logic [TIME_W-1:0] wait_b;
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  key_b;
    bit                earlier;
    earlier = q_rank[a] < q_rank[b];
    if (sel_mode == MODE_FCFS) begin
      if (q_arr[a] != q_arr[b]) return q_arr[a] < q_arr[b];
      return earlier;
    end
    if (sel_mode == MODE_RR) return earlier;
    // waiting time wraps at 32 bits, the key itself is kept at full width
    wait_a = now - q_stamp[a];
    wait_b = now - q_stamp[b];
    key_a = KEY_W'(q_prio[a]) + KEY_W'(wait_a) * KEY_W'(aging_wt);
    key_b = KEY_W'(q_prio[b]) + KEY_W'(wait_b) * KEY_W'(aging_wt);
    if (key_a != key_b) return key_a > key_b;
    return earlier;
  endfunction

  // applies one transaction to the predicted queue and returns its result
  function automatic dispatch_t compute_dispatch(item_t it);
    dispatch_t   d;
    int          win;
    logic [15:0] rank;
    d.status = ST_OK;
    d.id = '0;
    win = -1;
    if (it.op == OP_ENQUEUE) begin
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (!occ[i] && win < 0) win = i;
      if (win < 0) begin
        d.status = ST_FULL;
      end else begin
        occ[win] = 1'b1;
        q_pid[win] = it.pid;
        q_arr[win] = it.arrival;
        q_prio[win] = it.prio;
        q_stamp[win] = it.now;
        q_rank[win] = next_rank;
        next_rank = next_rank + 16'd1;
      end
    end else begin
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (occ[i] && (win < 0 || outranks(i, win, it.now))) win = i;
      if (win < 0) begin
        d.status = ST_EMPTY;
      end else begin
        rank = q_rank[win];
        occ[win] = 1'b0;
        d.id = q_pid[win];
        // close the gap in insertion ranks
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (occ[i] && q_rank[i] > rank) q_rank[i] = q_rank[i] - 16'd1;
        if (next_rank > 0) next_rank = next_rank - 16'd1;
      end
    end
    return d;
  endfunction

  // offer one transaction, wait for acceptance, queue its expected result
  task automatic send_item(item_t it, bit fixed, dispatch_t fixed_res);
    dispatch_t got;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= it.op;
    process_id    <= it.pid;
    arrived_at    <= it.arrival;
    base_priority <= it.prio;
    now_time      <= it.now;
    do @(posedge clk); while (in_ready !== 1'b1);
    got = compute_dispatch(it);
    owed_dispatch.push_back(fixed ? fixed_res : got);
    if (it.op == OP_ENQUEUE) n_enq++;
    else n_deq++;
    if (got.status == ST_FULL) n_full++;
    if (got.status == ST_EMPTY) n_empty++;
  endtask

  // stop offering and wait until every outstanding result is back
  task automatic drain_results(int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_dispatch.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_MODE) sel_mode = val[MODE_W-1:0];
    else aging_wt = val[WGT_W-1:0];
    n_reg_writes++;
  endtask

  // stimulus
  initial begin : stimulus
    item_t             it;
    dispatch_t         fixed_res;
    dispatch_t         no_fixed;
    logic [TIME_W-1:0] clock_now;
    logic [WGT_W-1:0]  wt;
    bit                filling;
    int                pick;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    operation     = OP_ENQUEUE;
    process_id    = '0;
    arrived_at    = '0;
    base_priority = '0;
    now_time      = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) occ[i] = 1'b0;
    next_rank     = '0;
    sel_mode      = MODE_FCFS;
    aging_wt      = '0;
    bad           = 0;
    n_results     = 0;
    n_enq         = 0;
    n_deq         = 0;
    n_full        = 0;
    n_empty       = 0;
    n_reg_writes  = 0;
    hold_requests = 0;
    tx_idle_pct   = 18;
    rx_idle_pct   = 59;
    no_fixed.status = ST_OK;
    no_fixed.id     = '0;
    filling   = 1'b1;
    clock_now = $urandom;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < NROWS; r++) begin
      if (plan[r].kind == ROW_MODE || plan[r].kind == ROW_WEIGHT) begin
        drain_results(CFG_SETTLE);
        write_reg(plan[r].kind == ROW_MODE ? REG_MODE : REG_WAIT_WEIGHT, plan[r].rval);
        @(negedge clk);
        cfg_write <= 1'b0;
      end else begin
        for (int k = 0; k < plan[r].reps; k++) begin
          it.op      = plan[r].op;
          it.pid     = plan[r].pid + PID_W'(k);
          it.arrival = plan[r].arrival + TIME_W'(k);
          it.prio    = plan[r].prio;
          it.now     = plan[r].now + TIME_W'(k);
          fixed_res.status = plan[r].st;
          fixed_res.id     = plan[r].id;
          send_item(it, plan[r].kind == ROW_FIXED, fixed_res);
        end
      end
    end

    // random traffic in chunks, one setting of both registers per chunk
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      tx_idle_pct = (c < 3) ? 18 : (c < 6) ? 59 : 0;
      rx_idle_pct = (c < 3) ? 59 : (c < 6) ? 18 : 0;
      drain_results(CFG_SETTLE);
      wt = (c == 0 || c == 7) ? 8'hFF : (c == 4) ? 8'h00 : (c == 3) ? 8'h01 :
           WGT_W'($urandom_range(0, 255));
      write_reg(REG_MODE, {(CFG_DATA_W - MODE_W)'($urandom), chunk_mode[c]});
      write_reg(REG_WAIT_WEIGHT, wt);
      @(negedge clk);
      cfg_write <= 1'b0;
      // long receiver stall while the sender keeps offering
      if (c == 3) hold_requests++;
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        // sender pause until the queue of results has emptied
        if (c % 2 == 1 && k == CHUNK_ITEMS / 2) drain_results(0);
        // swing between filling and draining so full and empty both come up
        if (next_rank == QUEUE_DEPTH) filling = 1'b0;
        else if (next_rank == 0) filling = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 6) it.op = 1'($urandom);
        else it.op = ((pick < 74) == filling) ? OP_ENQUEUE : OP_DEQUEUE;
        // mostly a slowly running clock, now and then a jump anywhere
        clock_now = clock_now + TIME_W'($urandom_range(0, 40));
        if ($urandom_range(0, 99) < 3) clock_now = $urandom;
        it.now = clock_now;
        pick = $urandom_range(0, 99);
        it.arrival = (pick < 50) ? clock_now - TIME_W'($urandom_range(0, 30)) :
                     (pick < 75) ? TIME_W'(1000 * $urandom_range(1, 3)) : TIME_W'($urandom);
        it.prio = ($urandom_range(0, 9) < 4) ? PRIO_W'($urandom_range(0, 3)) :
                  PRIO_W'($urandom);
        it.pid  = PID_W'($urandom);
        send_item(it, 1'b0, no_fixed);
      end
    end

    // wind down
    drain_results(0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_dispatch.size() != 0) begin
      bad += owed_dispatch.size();
      $display("%0d results never arrived", owed_dispatch.size());
    end
    $display("covered %0d transactions (%0d enqueue, %0d dequeue), %0d queue full, %0d empty",
             n_enq + n_deq, n_enq, n_deq, n_full, n_empty);
    $display("%0d register writes over all four policy codes, %0d results checked, %0d errors",
             n_reg_writes, n_results, bad);
    if (bad == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: random back-pressure plus an occasional long hold-off
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    hold_served = 0;
    out_ready   = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_result
    dispatch_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      n_results++;
      if (owed_dispatch.size() == 0) begin
        bad++;
        if (bad <= REPORT_LIMIT)
          $display("unexpected result: status %0d id 0x%02h", status, selected_id);
      end else begin
        want = owed_dispatch.pop_front();
        if (status !== want.status || selected_id !== want.id) begin
          bad++;
          if (bad <= REPORT_LIMIT)
            $display("mismatch on result %0d: status exp %0d got %0d, id exp 0x%02h got 0x%02h",
                     n_results, want.status, status, want.id, selected_id);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, owed_dispatch.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule
